/* hw/rtl/albs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the sorted array list with bisection search.
// Depends on nothing; imported by every module of the block.
package albs_pkg;

   localparam int WORD_W   = 32;
   localparam int POS_W    = 5;
   localparam int CAP_W    = 5;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int ACTION_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Actions carried by an input item.
   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

   // Status codes of a result item.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

   // Operations broadcast along the chain of cells.
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]               op;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [FOUND_W-1:0]       found_position;
      logic signed [WORD_W-1:0] read_value;
      logic [COUNT_W-1:0]       entry_count;
   } result_type;

endpackage

/* hw/rtl/array_list_with_binary_search_top.sv */
`timescale 1ns / 1ps
// Top level of the bounded sorted list: a chain of albs_cell word cells and the albs_ctrl sequencer.
// Depends on albs_pkg, albs_cell and albs_ctrl.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    action, position, value
//   rsp       out        rsp_valid/rsp_ready    status, found_position, read_value, entry_count
//   csr       in         csr_write_en           capacity (5 bits)
//
// Append, insert, delete and read are done by the sequencer while it is idle: every cell shifts at once.
// Find enters the search state, takes one bisection step per cycle through the single read port of
// the chain and reports a miss once the window is empty.
// The result sits in an output register; one further finished result can wait behind it.
// Reset is synchronous and clears count, capacity (to 16) and the handshakes; words need none.
// A new item is taken only while the sequencer is idle.
module array_list_with_binary_search_top
   import albs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [FOUND_W-1:0]         rsp_found_position,
   output logic signed [WORD_W-1:0]   rsp_read_value,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   input  logic                       csr_write_en,
   input  logic [CAP_W-1:0]           csr_write_data
);

   logic signed [WORD_W-1:0] row [DEPTH];
   cell_cmd_type             cmd;
   result_type               result;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_W-1:0] left_word;
      logic signed [WORD_W-1:0] right_word;

      if (g == 0) begin : g_first
         assign left_word = row[g];
      end else begin : g_inner_left
         assign left_word = row[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_word = row[g];
      end else begin : g_inner_right
         assign right_word = row[g+1];
      end

      albs_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_word),
         .right_data (right_word),
         .data       (row[g])
      );
   end

   albs_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result     (result),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .row            (row),
      .cmd            (cmd)
   );

   assign rsp_status         = result.status;
   assign rsp_found_position = result.found_position;
   assign rsp_read_value     = result.read_value;
   assign rsp_entry_count    = result.entry_count;

endmodule

/* hw/rtl/albs_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the list: holds one word and takes its neighbor's word on a shift.
// Depends on albs_pkg for the command struct and operation codes.
module albs_cell
   import albs_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic signed [WORD_W-1:0] left_data,
   input  logic signed [WORD_W-1:0] right_data,
   output logic signed [WORD_W-1:0] data
);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            // Cells above the slot move up; the slot itself takes the new word.
            if (32'(INDEX) == 32'(cmd.pos)) begin
               data_in = cmd.value;
            end else if (32'(INDEX) > 32'(cmd.pos)) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (32'(INDEX) >= 32'(cmd.pos)) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* hw/rtl/albs_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the list: used count, capacity register, bisection search and result registers.
// Depends on albs_pkg; drives the command that the chain of albs_cell instances executes.
module albs_ctrl
   import albs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output result_type               rsp_result,
   input  logic                     csr_write_en,
   input  logic [CAP_W-1:0]         csr_write_data,
   input  logic signed [WORD_W-1:0] row [DEPTH],
   output cell_cmd_type             cmd
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_HOLD   = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            low_ff, low_in;
   logic [CW-1:0]            hp_ff, hp_in;
   logic signed [WORD_W-1:0] key_ff, key_in;
   logic [CAP_W-1:0]         capacity_ff;
   result_type               hold_ff, hold_in;
   result_type               rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     out_free;
   logic                     full;
   logic                     finish;
   result_type               res;
   logic [CW:0]              mid_sum;
   logic [IW-1:0]            mid;
   logic [IW-1:0]            rd_idx;
   logic signed [WORD_W-1:0] rd_word;

   // hp_ff holds the upper bound plus one, so the window is empty when low reaches it.
   assign mid_sum = (CW+1)'(low_ff) + (CW+1)'(hp_ff) - (CW+1)'(1);
   assign mid     = IW'(mid_sum >> 1);
   assign rd_idx  = (state_ff == S_SEARCH) ? mid : IW'(req_position);
   assign rd_word = row[rd_idx];

   assign full     = (32'(count_ff) >= 32'(capacity_ff)) || (32'(count_ff) >= DEPTH);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      hp_in        = hp_ff;
      key_in       = key_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '{op: CELL_HOLD, pos: '0, value: '0};
      finish       = 1'b0;
      res          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               finish = 1'b1;
               unique case (req_action)
                  ACT_APPEND: begin
                     if (full) begin
                        res.status = ST_FULL;
                     end else begin
                        // An append is an insert at the slot just past the last entry.
                        cmd      = '{op: CELL_INSERT, pos: POS_W'(count_ff), value: req_value};
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ACT_INSERT: begin
                     if (32'(req_position) > 32'(count_ff)) begin
                        res.status = ST_RANGE;
                     end else if (full) begin
                        res.status = ST_FULL;
                     end else begin
                        cmd      = '{op: CELL_INSERT, pos: req_position, value: req_value};
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ACT_DELETE: begin
                     if (32'(req_position) >= 32'(count_ff)) begin
                        res.status = ST_RANGE;
                     end else begin
                        cmd      = '{op: CELL_DELETE, pos: req_position, value: req_value};
                        count_in = count_ff - CW'(1);
                     end
                  end
                  ACT_FIND: begin
                     finish   = 1'b0;
                     state_in = S_SEARCH;
                     low_in   = '0;
                     hp_in    = count_ff;
                     key_in   = req_value;
                  end
                  ACT_READ: begin
                     if (32'(req_position) >= 32'(count_ff)) begin
                        res.status = ST_RANGE;
                     end else begin
                        res.read_value = rd_word;
                     end
                  end
                  default: begin
                     res.status = ST_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (low_ff >= hp_ff) begin
               finish     = 1'b1;
               res.status = ST_MISS;
            end else if (rd_word == key_ff) begin
               finish             = 1'b1;
               res.found_position = FOUND_W'(mid);
            end else if (rd_word < key_ff) begin
               low_in = CW'(mid) + CW'(1);
            end else begin
               hp_in = CW'(mid);
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.entry_count = COUNT_W'(count_in);

      // A finished result goes straight out if the output slot is free, else it waits.
      if (finish) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            hold_in  = res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      hp_ff   <= hp_in;
      key_ff  <= key_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

/* hw/rtl/albs_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the sorted list top level, bound to it below.
// Depends on albs_pkg for the status codes.
module albs_checker
   import albs_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic [FOUND_W-1:0]       rsp_found_position,
   input logic signed [WORD_W-1:0] rsp_read_value,
   input logic [COUNT_W-1:0]       rsp_entry_count
);

   // A stalled result item stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_entry_count)
         && $stable(rsp_found_position))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A miss reports no position.
   a_miss_no_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_MISS |-> rsp_found_position == '0)
      else $error("miss carries a position");

   // Only a successful read returns a word.
   a_refused_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("refused item carries a read word");

endmodule

bind array_list_with_binary_search_top albs_checker u_albs_checker (.*);

/* dv/albs_list_checker.sv */
`timescale 1ns / 1ps
// Checker for the bounded list: watches the request, result and capacity ports, predicts each
// result item, and compares it field by field. Depends on albs_pkg.
module albs_list_checker
   import albs_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [STATUS_W-1:0]      rsp_status,
   input  logic [FOUND_W-1:0]       rsp_found_position,
   input  logic signed [WORD_W-1:0] rsp_read_value,
   input  logic [COUNT_W-1:0]       rsp_entry_count,
   input  logic                     csr_write_en,
   input  logic [CAP_W-1:0]         csr_write_data,
   output int                       mismatches,
   output int                       outstanding,
   output int                       results_checked,
   output int                       find_hits,
   output int                       full_refusals,
   output int                       range_refusals
);

   localparam int MAX_REPORTS = 40;

   logic signed [WORD_W-1:0] words [LIST_DEPTH];
   logic [COUNT_W-1:0]       used;
   logic [CAP_W-1:0]         capacity_reg;
   result_type               expected_results [$];

   task automatic report_failure(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   // Applies one item to the shadow list and returns the result it should produce.
   function automatic result_type apply_list_action(input logic [ACTION_W-1:0] act,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic signed [WORD_W-1:0] val);
      result_type res;
      int         limit;
      int         i;
      int         lo;
      int         hi;
      int         mid;
      logic       hit;
      res = '0;
      limit = (capacity_reg < LIST_DEPTH) ? int'(capacity_reg) : LIST_DEPTH;
      case (act)
         ACT_APPEND: begin
            if (used >= limit) begin
               res.status = ST_FULL;
            end else begin
               words[used] = val;
               used = used + 1'b1;
            end
         end
         ACT_INSERT: begin
            // The position check wins over the full check.
            if (pos > used) begin
               res.status = ST_RANGE;
            end else if (used >= limit) begin
               res.status = ST_FULL;
            end else begin
               for (i = used; i > pos; i--) begin
                  words[i] = words[i - 1];
               end
               words[pos] = val;
               used = used + 1'b1;
            end
         end
         ACT_DELETE: begin
            if (pos >= used) begin
               res.status = ST_RANGE;
            end else begin
               for (i = pos; i + 1 < used; i++) begin
                  words[i] = words[i + 1];
               end
               used = used - 1'b1;
            end
         end
         ACT_FIND: begin
            lo = 0;
            hi = int'(used) - 1;
            hit = 1'b0;
            while (lo <= hi && !hit) begin
               mid = (lo + hi) / 2;
               if (words[mid] == val) begin
                  res.found_position = FOUND_W'(mid);
                  hit = 1'b1;
               end else if (words[mid] < val) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
            if (hit) begin
               find_hits++;
            end else begin
               res.status = ST_MISS;
            end
         end
         ACT_READ: begin
            if (pos >= used) begin
               res.status = ST_RANGE;
            end else begin
               res.read_value = words[pos];
            end
         end
         default: begin
         end
      endcase
      if (res.status == ST_FULL) full_refusals++;
      if (res.status == ST_RANGE) range_refusals++;
      res.entry_count = used;
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      result_type want;
      if (reset) begin
         expected_results.delete();
         used = '0;
         capacity_reg = CAP_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               report_failure($sformatf("result %0d arrived with nothing expected",
                                        results_checked));
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_failure($sformatf("result %0d status %0d, expected %0d",
                                           results_checked, rsp_status, want.status));
               if (rsp_found_position !== want.found_position)
                  report_failure($sformatf("result %0d found_position %0d, expected %0d",
                                           results_checked, rsp_found_position,
                                           want.found_position));
               if (rsp_read_value !== want.read_value)
                  report_failure($sformatf("result %0d read_value %0d, expected %0d",
                                           results_checked, rsp_read_value, want.read_value));
               if (rsp_entry_count !== want.entry_count)
                  report_failure($sformatf("result %0d entry_count %0d, expected %0d",
                                           results_checked, rsp_entry_count,
                                           want.entry_count));
            end
         end
         if (csr_write_en) begin
            capacity_reg = csr_write_data;
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_list_action(req_action, req_position, req_value));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

/* dv/array_list_with_binary_search_top_tb.sv */
`timescale 1ns / 1ps
// Top of the bounded list testbench: clock, reset, request and capacity stimulus, result
// back-pressure and the verdict. Depends on albs_pkg, albs_list_checker and the block's RTL.
module array_list_with_binary_search_top_tb;
   import albs_pkg::*;

   localparam int LIST_DEPTH    = 16;
   localparam int ITEM_TARGET   = 1800;
   localparam int TAIL_ITEMS    = 200;
   localparam int HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 500000;

   localparam logic [ACTION_W-1:0]      ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0]      ACT_SPARE_LAST  = 3'd7;
   localparam logic signed [WORD_W-1:0] WORD_MIN        = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX        = 32'sh7FFF_FFFF;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ACTION_W-1:0]      req_action = ACT_APPEND;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [FOUND_W-1:0]       rsp_found_position;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0]       rsp_entry_count;
   logic                     csr_write_en = 1'b0;
   logic [CAP_W-1:0]         csr_write_data = CAP_RESET;

   logic no_idle = 1'b0;
   int   hold_token = 0;
   int   items_sent = 0;
   int   capacity_writes = 0;
   int   cycle_count = 0;
   logic signed [WORD_W-1:0] round_keys [LIST_DEPTH + 2];

   int mismatches;
   int outstanding;
   int results_checked;
   int find_hits;
   int full_refusals;
   int range_refusals;

   array_list_with_binary_search_top #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position),
      .rsp_read_value(rsp_read_value),
      .rsp_entry_count(rsp_entry_count),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   albs_list_checker #(
      .LIST_DEPTH(LIST_DEPTH)
   ) list_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position),
      .rsp_read_value(rsp_read_value),
      .rsp_entry_count(rsp_entry_count),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .mismatches(mismatches),
      .outstanding(outstanding),
      .results_checked(results_checked),
      .find_hits(find_hits),
      .full_refusals(full_refusals),
      .range_refusals(range_refusals)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, outstanding);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random stalls, runs of steady readiness, and a long hold-off on request.
   initial begin : result_receiver
      int holds_served;
      int span;
      holds_served = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_token != holds_served) begin
            holds_served = holds_served + 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = $urandom_range(1, 24);
            rsp_ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Offers one item and returns at the edge that accepts it, sometimes followed by a gap.
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                            input logic signed [WORD_W-1:0] val);
      int gap;
      req_action <= act;
      req_position <= pos;
      req_value <= val;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (act <= ACT_READ) items_sent++;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_until_drained();
      csr_write_en <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      csr_write_en <= 1'b0;
      capacity_writes++;
   endtask

   function automatic logic [CAP_W-1:0] pick_capacity();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return CAP_W'(1);
         2, 3:    return CAP_W'(LIST_DEPTH);
         4:       return '1;
         default: return CAP_W'($urandom_range(2, LIST_DEPTH - 1));
      endcase
   endfunction

   task automatic send_noise_item();
      logic [POS_W-1:0] pos;
      if ($urandom_range(0, 1) == 0) pos = POS_W'($urandom_range(0, LIST_DEPTH));
      else pos = POS_W'($urandom);
      send_item(ACTION_W'($urandom_range(ACT_APPEND, ACT_SPARE_LAST)), pos, $urandom);
   endtask

   task automatic run_noise_burst();
      int n;
      int i;
      n = $urandom_range(10, 30);
      for (i = 0; i < n; i++) send_noise_item();
   endtask

   // The receiver stops for a long while; the sender keeps offering so the block backs up.
   task automatic run_backpressure();
      int i;
      hold_token <= hold_token + 1;
      for (i = 0; i < LIST_DEPTH; i++) send_noise_item();
   endtask

   // Empties the list, loads it in ascending order and searches it, with a few edits mixed in.
   task automatic run_sorted_round();
      int   n;
      int   ops;
      int   pick;
      int   k;
      int   i;
      int   j;
      logic narrow;
      logic signed [WORD_W-1:0] key;
      narrow = ($urandom_range(0, 2) == 0);
      n = $urandom_range(1, LIST_DEPTH + 2);
      for (i = 0; i < LIST_DEPTH; i++) send_item(ACT_DELETE, '0, $urandom);
      for (i = 0; i < n; i++) begin
         if (narrow) key = $urandom_range(0, 40) - 20;
         else key = $urandom;
         if ($urandom_range(0, 15) == 0) key = ($urandom_range(0, 1) == 0) ? WORD_MIN : WORD_MAX;
         j = i;
         while (j > 0 && round_keys[j - 1] > key) begin
            round_keys[j] = round_keys[j - 1];
            j--;
         end
         round_keys[j] = key;
      end
      for (i = 0; i < n; i++) send_item(ACT_APPEND, POS_W'($urandom), round_keys[i]);
      ops = $urandom_range(n, 3 * n + 2);
      for (i = 0; i < ops; i++) begin
         k = $urandom_range(0, n - 1);
         pick = $urandom_range(0, 19);
         if (pick < 8) send_item(ACT_FIND, POS_W'($urandom), round_keys[k]);
         else if (pick < 10) send_item(ACT_FIND, POS_W'($urandom), round_keys[k] + 1);
         else if (pick < 11) send_item(ACT_FIND, POS_W'($urandom), round_keys[k] - 1);
         else if (pick < 12) send_item(ACT_FIND, POS_W'($urandom), $urandom);
         else if (pick < 16) send_item(ACT_READ, POS_W'($urandom_range(0, n)), $urandom);
         else if (pick < 18) send_item(ACT_DELETE, POS_W'($urandom_range(0, n)), $urandom);
         else if (pick < 19) send_item(ACT_INSERT, POS_W'($urandom_range(0, n)), $urandom);
         else send_noise_item();
      end
   endtask

   initial begin : stimulus
      int mode;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty list: every lookup is refused.
      send_item(ACT_FIND, '0, 32'sd5);
      send_item(ACT_READ, '0, '0);
      send_item(ACT_DELETE, '0, '0);
      send_item(ACT_INSERT, POS_W'(1), 32'sd7);
      // Build an unsorted list from the word extremes, inserting at the front and at the end.
      send_item(ACT_INSERT, '0, WORD_MIN);
      send_item(ACT_APPEND, '1, WORD_MAX);
      send_item(ACT_INSERT, POS_W'(2), '0);
      send_item(ACT_READ, '0, '0);
      send_item(ACT_READ, POS_W'(2), '0);
      send_item(ACT_READ, '1, '0);
      send_item(ACT_FIND, '0, WORD_MIN);
      send_item(ACT_FIND, '0, WORD_MAX);
      send_item(ACT_FIND, '0, '0);
      send_item(ACT_INSERT, POS_W'(1), -32'sd1);
      send_item(ACT_DELETE, POS_W'(3), '0);
      send_item(ACT_FIND, '1, -32'sd1);
      send_item(ACT_SPARE_FIRST, POS_W'(3), $urandom);
      send_item(ACT_SPARE_LAST, '1, $urandom);
      // Zero capacity refuses every growth; a bad insert position is reported first.
      write_capacity('0);
      send_item(ACT_APPEND, '0, 32'sd9);
      send_item(ACT_INSERT, '0, 32'sd9);
      send_item(ACT_INSERT, '1, 32'sd9);
      // Capacity below the stored count keeps the entries and refuses growth.
      write_capacity(CAP_W'(1));
      send_item(ACT_APPEND, '0, 32'sd11);
      send_item(ACT_DELETE, '0, '0);
      send_item(ACT_READ, '0, '0);
      write_capacity('1);

      run_backpressure();
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - TAIL_ITEMS) no_idle <= 1'b1;
         mode = $urandom_range(0, 19);
         if (mode < 12) run_sorted_round();
         else if (mode < 15) run_noise_burst();
         else if (mode < 18) write_capacity(pick_capacity());
         else if (!no_idle) run_backpressure();
      end

      wait_until_drained();
      $display("Sent %0d list actions and checked %0d results over %0d capacity settings.",
               items_sent, results_checked, capacity_writes + 1);
      $display("Search hits: %0d, full refusals: %0d, position refusals: %0d.",
               find_hits, full_refusals, range_refusals);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/albs_pkg.sv
hw/rtl/albs_cell.sv
hw/rtl/albs_ctrl.sv
hw/rtl/array_list_with_binary_search_top.sv
hw/rtl/albs_checker.sv
dv/albs_list_checker.sv
dv/array_list_with_binary_search_top_tb.sv
